FILE: rtl/core/hsd_pkg.sv
// package: types, constants and hash functions for the hashed string dictionary
package hsd_pkg;
   localparam int BucketsDefault = 16;
   localparam int EntriesDefault = 8;
   localparam int MaxKeyLenDefault = 32;
   localparam int ValueWidthDefault = 32;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_TOO_LONG  = 3'd5;

   typedef struct packed {
      logic        kind;
      logic [6:0]  key_byte;
      logic        last;
      logic [31:0] insert_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_value;
   } rsp_type;

   function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [6:0] b);
      logic [31:0] t;
      t = h + {25'd0, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [31:0] hash_finish(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction
endpackage

FILE: rtl/core/hsd_key_buf.sv
// pending key buffer: byte memory written as the key arrives, read during compare and copy
module hsd_key_buf
   import hsd_pkg::*;
#(
   parameter int MAX_KEY_LEN = MaxKeyLenDefault,
   localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [6:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [6:0]    rd_data
);
   logic [6:0] mem [MAX_KEY_LEN];
   logic [6:0] rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

FILE: rtl/core/hsd_store.sv
// slot store: key byte memory, key length memory and value memory
module hsd_store
   import hsd_pkg::*;
#(
   parameter int SLOTS = BucketsDefault * EntriesDefault,
   parameter int MAX_KEY_LEN = MaxKeyLenDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1,
   localparam int LW = $clog2(MAX_KEY_LEN + 2)
) (
   input  logic                   clock,
   input  logic                   kb_wr_en,
   input  logic [SW+AW-1:0]       kb_wr_addr,
   input  logic [6:0]             kb_wr_data,
   input  logic [SW+AW-1:0]       kb_rd_addr,
   output logic [6:0]             kb_rd_data,
   input  logic                   sl_wr_en,
   input  logic [SW-1:0]          sl_wr_addr,
   input  logic [LW-1:0]          sl_wr_len,
   input  logic [VALUE_WIDTH-1:0] sl_wr_value,
   input  logic [SW-1:0]          sl_rd_addr,
   output logic [LW-1:0]          sl_rd_len,
   output logic [VALUE_WIDTH-1:0] sl_rd_value
);
   logic [6:0]             kb_mem [SLOTS*(2**AW)];
   logic [LW-1:0]          len_mem [SLOTS];
   logic [VALUE_WIDTH-1:0] val_mem [SLOTS];
   logic [6:0]             kb_ff;
   logic [LW-1:0]          len_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   always_ff @(posedge clock) begin
      if (kb_wr_en) kb_mem[kb_wr_addr] <= kb_wr_data;
      kb_ff <= kb_mem[kb_rd_addr];
   end
   always_ff @(posedge clock) begin
      if (sl_wr_en) begin
         len_mem[sl_wr_addr] <= sl_wr_len;
         val_mem[sl_wr_addr] <= sl_wr_value;
      end
      len_ff <= len_mem[sl_rd_addr];
      val_ff <= val_mem[sl_rd_addr];
   end
   assign kb_rd_data = kb_ff;
   assign sl_rd_len = len_ff;
   assign sl_rd_value = val_ff;
endmodule

FILE: rtl/core/hashed_string_dictionary_core.sv
// top level: hashed string dictionary core with bucket scan sequencer
//  channel | ports       | transfer
//  request | req_*       | start high and busy low at a rising edge
//  result  | rsp_*       | rsp_valid high for one cycle
// a non-last byte is mixed into the hash when taken; busy stays low
// a last byte keeps busy high for a final mix state and a done state; between them, per
// scanned entry a length state plus up to key length compare states, a closing scan state
// if none matches (no scan for a too-long key), on insert a read and write state per byte
// rsp_valid rises in the first cycle with busy low; the receiver cannot stall it
// reset clears fill counters and the key gatherer; no clearing pass
module hashed_string_dictionary_core
   import hsd_pkg::*;
#(
   parameter int BUCKETS = BucketsDefault,
   parameter int ENTRIES_PER_BUCKET = EntriesDefault,
   parameter int MAX_KEY_LEN = MaxKeyLenDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int SLOTS = BUCKETS * ENTRIES_PER_BUCKET;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW = $clog2(BUCKETS);
   localparam int EW = $clog2(ENTRIES_PER_BUCKET + 1);
   localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int LW = $clog2(MAX_KEY_LEN + 2);
   localparam int VW = VALUE_WIDTH < 32 ? VALUE_WIDTH : 32;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FIN  = 3'd1;
   localparam logic [2:0] S_LEN  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_CPY  = 3'd4;
   localparam logic [2:0] S_CPW  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [31:0]            hash_ff, hash_in;
   logic [LW-1:0]          cnt_ff, cnt_in;
   logic [EW-1:0]          fill_ff [BUCKETS];
   logic                   fill_we;
   logic [BW-1:0]          bkt_ff, bkt_in;
   logic [EW-1:0]          ent_ff, ent_in;
   logic [EW-1:0]          nfill_ff, nfill_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [LW-1:0]          idx_ff, idx_in;
   logic                   kind_ff, kind_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [2:0]             st_ff, st_in;
   logic [VALUE_WIDTH-1:0] fv_ff, fv_in;
   logic                   rv_ff, rv_in;
   logic                   accept;
   logic [31:0]            fin;

   logic [AW-1:0]          kq_wa, kq_ra;
   logic [6:0]             kq_rd;
   logic                   kb_we, sl_we;
   logic [SW+AW-1:0]       kb_wa, kb_ra;
   logic [6:0]             kb_rd;
   logic [SW-1:0]          slot_ent, slot_new;
   logic [LW-1:0]          sl_len;
   logic [VALUE_WIDTH-1:0] sl_val;

   assign accept = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign fin = hash_finish(hash_ff);
   assign kq_wa = cnt_ff[AW-1:0];
   assign slot_ent = SW'(bkt_ff * ENTRIES_PER_BUCKET + ent_ff);
   assign slot_new = SW'(bkt_ff * ENTRIES_PER_BUCKET + nfill_ff);

   hsd_key_buf #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_key (
      .clock(clock), .wr_en(accept && cnt_ff < LW'(MAX_KEY_LEN)), .wr_addr(kq_wa),
      .wr_data(req_data.key_byte), .rd_addr(kq_ra), .rd_data(kq_rd));

   hsd_store #(.SLOTS(SLOTS), .MAX_KEY_LEN(MAX_KEY_LEN), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
      .clock(clock), .kb_wr_en(kb_we), .kb_wr_addr(kb_wa), .kb_wr_data(kq_rd),
      .kb_rd_addr(kb_ra), .kb_rd_data(kb_rd), .sl_wr_en(sl_we), .sl_wr_addr(slot_new),
      .sl_wr_len(len_ff), .sl_wr_value(val_ff), .sl_rd_addr(slot_ent),
      .sl_rd_len(sl_len), .sl_rd_value(sl_val));

   always_comb begin
      state_in = state_ff;
      hash_in = hash_ff;
      cnt_in = cnt_ff;
      bkt_in = bkt_ff;
      ent_in = ent_ff;
      nfill_in = nfill_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      kind_in = kind_ff;
      val_in = val_ff;
      st_in = st_ff;
      fv_in = fv_ff;
      rv_in = 1'b0;
      fill_we = 1'b0;
      kb_we = 1'b0;
      sl_we = 1'b0;
      kq_ra = idx_ff[AW-1:0];
      kb_ra = {slot_ent, idx_ff[AW-1:0]};
      kb_wa = {slot_new, AW'(idx_ff - LW'(1))};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hash_in = hash_mix(hash_ff, req_data.key_byte);
               if (cnt_ff <= LW'(MAX_KEY_LEN)) cnt_in = cnt_ff + LW'(1);
               if (req_data.last) begin
                  len_in = (cnt_ff <= LW'(MAX_KEY_LEN)) ? cnt_ff + LW'(1) : cnt_ff;
                  kind_in = req_data.kind;
                  val_in = VALUE_WIDTH'(req_data.insert_value);
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            bkt_in = BW'(fin % BUCKETS);
            hash_in = '0;
            cnt_in = '0;
            ent_in = '0;
            st_in = kind_ff ? ST_NOT_FOUND : ST_INSERTED;
            fv_in = '0;
            if (len_ff > LW'(MAX_KEY_LEN)) begin
               st_in = ST_TOO_LONG;
               state_in = S_DONE;
            end else begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            nfill_in = fill_ff[bkt_ff];
            idx_in = '0;
            kq_ra = '0;
            kb_ra = {slot_ent, {AW{1'b0}}};
            if (ent_ff >= fill_ff[bkt_ff]) begin
               state_in = S_DONE;
               if (!kind_ff) begin
                  if (fill_ff[bkt_ff] >= EW'(ENTRIES_PER_BUCKET)) st_in = ST_FULL;
                  else state_in = S_CPY;
               end
            end else begin
               idx_in = LW'(1);
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            kq_ra = idx_ff[AW-1:0];
            kb_ra = {slot_ent, idx_ff[AW-1:0]};
            if (sl_len != len_ff || kq_rd != kb_rd) begin
               ent_in = ent_ff + EW'(1);
               state_in = S_LEN;
            end else if (idx_ff == len_ff) begin
               state_in = S_DONE;
               if (kind_ff) begin
                  st_in = ST_FOUND;
                  fv_in = sl_val;
               end else begin
                  st_in = ST_DUPLICATE;
               end
            end else begin
               idx_in = idx_ff + LW'(1);
            end
         end
         S_CPY: begin
            kq_ra = idx_ff[AW-1:0];
            idx_in = idx_ff + LW'(1);
            state_in = S_CPW;
         end
         S_CPW: begin
            kb_we = 1'b1;
            if (idx_ff == len_ff) begin
               sl_we = 1'b1;
               fill_we = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_CPY;
            end
         end
         S_DONE: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hash_ff <= '0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) fill_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         if (fill_we) fill_ff[bkt_ff] <= nfill_ff + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      bkt_ff <= bkt_in;
      ent_ff <= ent_in;
      nfill_ff <= nfill_in;
      len_ff <= len_in;
      idx_ff <= idx_in;
      kind_ff <= kind_in;
      val_ff <= val_in;
      st_ff <= st_in;
      fv_ff <= fv_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data.status = st_ff;
   assign rsp_data.found_value = 32'(fv_ff[VW-1:0]);

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> nfill_ff < EW'(ENTRIES_PER_BUCKET)) else $error("bucket overfill");
endmodule
